// ===== rtl/core/s256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
`default_nettype none

package s256_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       msg_end;
  } cmd_t;

  typedef struct packed {
    logic  load;
    hash_t words;
  } dig_t;

  localparam hash_t IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] k_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/s256_front.sv =====
// Input acceptance, item classification and the command queue toward the engine.
`default_nettype none

module s256_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             byte_present,
  input  logic             message_end,
  output s256_pkg::cmd_t   cmd,
  output logic             cmd_valid,
  input  logic             cmd_pop
);
  import s256_pkg::*;

  cmd_t               entries [QDEPTH];
  logic [QAW-1:0]     wr_ptr;
  logic [QAW-1:0]     rd_ptr;
  logic [QAW:0]       count;
  logic               push;
  logic               pop;

  // Items that carry neither a byte nor an end change nothing and are dropped here.
  assign in_ready  = (count != (QAW+1)'(QDEPTH)) ? 1'b1 : 1'b0;
  assign push      = in_valid && in_ready && (byte_present || message_end);
  assign cmd_valid = (count != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{data: data_byte, present: byte_present, msg_end: message_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/s256_back.sv =====
// Byte packing, padding, message schedule and the round engine with hash chaining.
`default_nettype none

module s256_back (
  input  logic           clk,
  input  logic           rst,
  input  s256_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  input  logic           out_busy,
  output s256_pkg::dig_t dig
);
  import s256_pkg::*;

  typedef enum logic [3:0] {
    ST_TAKE = 4'b0001,
    ST_PAD  = 4'b0010,
    ST_COMP = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t              state;
  logic [5:0]          pos;
  logic [63:0]         bits;
  logic                pad_mode;
  logic                pad_first;
  logic                len_phase;
  logic                len_done;
  logic [5:0]          round;
  hash_t               chain;
  hash_t               wv;
  logic [15:0][31:0]   blk;

  logic                put_en;
  logic [7:0]          put_val;
  logic                len_now;
  logic                block_full;
  logic [31:0]         t1;
  logic [31:0]         t2;
  logic [31:0]         w_new;
  hash_t               fin_sum;

  // Length bytes go out while the slot is in the last eight bytes of the final block.
  assign len_now    = !pad_first && (len_phase || (pos == 6'd56));
  assign block_full = put_en && (pos == 6'd63);

  always_comb begin
    put_en  = 1'b0;
    put_val = 8'h00;
    cmd_pop = 1'b0;
    case (state)
      ST_TAKE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          put_en  = cmd.present;
          put_val = cmd.data;
        end
      end
      ST_PAD: begin
        put_en = 1'b1;
        if (pad_first) begin
          put_val = PAD_BYTE;
        end else if (len_now) begin
          put_val = bits[{~pos[2:0], 3'b000} +: 8];
        end else begin
          put_val = 8'h00;
        end
      end
      default: begin
        put_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    t1 = wv[7] + bsig1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + k_const(round)
         + blk[0];
    t2 = bsig0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
    w_new = ssig1(blk[14]) + blk[9] + ssig0(blk[1]) + blk[0];
    for (int i = 0; i < 8; i++) begin
      fin_sum[i] = chain[i] + wv[i];
    end
  end

  assign dig.load  = (state == ST_FIN) && len_done && !out_busy;
  assign dig.words = fin_sum;

  always_ff @(posedge clk) begin
    if (state == ST_COMP) begin
      blk <= {w_new, blk[15:1]};
    end else if (put_en) begin
      blk[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= put_val;
    end
    if ((state == ST_TAKE || state == ST_PAD) && block_full) begin
      wv <= chain;
    end else if (state == ST_COMP) begin
      wv <= {wv[6], wv[5], wv[4], wv[3] + t1, wv[2], wv[1], wv[0], t1 + t2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_TAKE;
      pos       <= '0;
      bits      <= '0;
      pad_mode  <= 1'b0;
      pad_first <= 1'b0;
      len_phase <= 1'b0;
      len_done  <= 1'b0;
      round     <= '0;
      chain     <= IV;
    end else begin
      if (put_en) begin
        pos <= pos + 6'd1;
      end
      case (state)
        ST_TAKE: begin
          if (cmd_valid) begin
            if (cmd.present) begin
              bits <= {bits[63:3] + 61'd1, bits[2:0]};
            end
            if (cmd.msg_end) begin
              pad_mode  <= 1'b1;
              pad_first <= 1'b1;
            end
            if (block_full) begin
              state <= ST_COMP;
              round <= '0;
            end else if (cmd.msg_end) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          if (len_now) begin
            len_phase <= 1'b1;
          end
          if (block_full) begin
            state <= ST_COMP;
            round <= '0;
            if (len_now) begin
              len_done <= 1'b1;
            end
          end
        end
        ST_COMP: begin
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (len_done) begin
            if (!out_busy) begin
              chain     <= IV;
              bits      <= '0;
              pad_mode  <= 1'b0;
              len_phase <= 1'b0;
              len_done  <= 1'b0;
              state     <= ST_TAKE;
            end
          end else begin
            chain <= fin_sum;
            state <= pad_mode ? ST_PAD : ST_TAKE;
          end
        end
        default: begin
          state <= ST_TAKE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/s256_out.sv =====
// Digest output buffer that hands out the eight digest words one item at a time.
`default_nettype none

module s256_out (
  input  logic           clk,
  input  logic           rst,
  input  s256_pkg::dig_t dig,
  output logic           busy,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    digest_word,
  output logic [2:0]     word_index,
  output logic           last_word
);
  import s256_pkg::*;

  hash_t       words;
  logic [2:0]  idx;
  logic        valid;

  assign busy        = valid;
  assign out_valid   = valid;
  assign digest_word = words[0];
  assign word_index  = idx;
  assign last_word   = (idx == 3'd7);

  always_ff @(posedge clk) begin
    if (dig.load) begin
      words <= dig.words;
    end else if (valid && out_ready) begin
      words <= {32'h0, words[7:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else begin
      if (dig.load) begin
        valid <= 1'b1;
        idx   <= '0;
      end else if (valid && out_ready) begin
        idx <= idx + 3'd1;
        if (idx == 3'd7) begin
          valid <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher: front queue, round engine and digest buffer.
//
//   Channel  Direction  Handshake             Item
//   input    in         in_valid / in_ready   data_byte, byte_present, message_end
//   output   out        out_valid / out_ready digest_word, word_index, last_word
//
// A byte is placed in the block when the engine takes it; a full block then goes through
// 64 rounds and one chaining step, and the engine takes no new byte until these are done.
// At message end padding goes in a byte per cycle outside the one or two more compressions.
// The four-entry input queue takes items while the engine compresses.
// Reset is synchronous and restores the initial hash; the digest buffer holds one digest,
// and the engine stalls at the end of the next message until that buffer has drained.
`default_nettype none

module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import s256_pkg::*;

  cmd_t  cmd;
  logic  cmd_valid;
  logic  cmd_pop;
  logic  out_busy;
  dig_t  dig;

  s256_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .message_end  (message_end),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop)
  );

  s256_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_busy  (out_busy),
    .dig       (dig)
  );

  s256_out u_out (
    .clk         (clk),
    .rst         (rst),
    .dig         (dig),
    .busy        (out_busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("Engine took a command from an empty queue.");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    dig.load |-> !out_valid)
    else $error("Digest loaded while the previous digest was still draining.");

  a_last_then_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> !out_valid)
    else $error("Output stayed valid after the last digest word was taken.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!out_valid && cmd_valid == 1'b0))
    else $error("Output or queue not empty after reset.");

endmodule

`default_nettype wire
